/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the rotation block; the top file includes them.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

/* rtl/core/rpc_pkg.sv */
// Shared types and constants of the point rotation pipeline.
// No dependencies; every module of the block imports this package.
`default_nettype none

package rpc_pkg;

    // Coordinate and angle formats.
    localparam int COORD_BITS     = 16;
    localparam int DELTA_BITS     = COORD_BITS + 1;
    localparam int ANGLE_BITS     = 20;
    localparam int DEG_FRAC_BITS  = 8;
    localparam int PHASE_BITS     = 32;
    localparam int Q_BITS         = 30;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // One in Q30, which is also a quarter turn of the phase.
    localparam logic [Q_BITS:0] Q30_ONE = {1'b1, {Q_BITS{1'b0}}};

    // Angle conversion constants.
    localparam logic [29:0] TURN_PER_RAD_Q32 = 30'd683565276;
    localparam logic [31:0] TWO_PI_Q29       = 32'd3373259426;
    localparam int DEG_HALF_CIRCLE = 180;
    localparam int DEG_FULL_CIRCLE = 2 * DEG_HALF_CIRCLE;
    localparam int QUADRANTS       = 4;
    localparam int QUAD_BITS       = $clog2(QUADRANTS);

    // 2^24/360 equals 2^21/45, so degrees are split by 45.
    localparam int DEG_STEP       = DEG_FULL_CIRCLE / 8;
    localparam int DEG_STEP_LOG   = 21;
    localparam int DEG_Q_BITS     = 15;
    localparam int DEG_K_BITS     = 6;
    localparam logic [20:0] DEG_STEP_RECIP = 21'd1491309;
    localparam int DEG_STEP_SHIFT = 26;

    // Exact reciprocals for 30-bit dividends: ceil(2^(30+l)/d), l = ceil(log2 d).
    localparam logic [30:0] RECIP_72 = 31'd1908874354;
    localparam int          SHIFT_72 = 37;
    localparam logic [30:0] RECIP_42 = 31'd1636178018;
    localparam int          SHIFT_42 = 36;
    localparam logic [30:0] RECIP_20 = 31'd1717986919;
    localparam int          SHIFT_20 = 35;
    localparam logic [30:0] RECIP_6  = 31'd1431655766;
    localparam int          SHIFT_6  = 33;
    localparam logic [30:0] RECIP_90 = 31'd1527099484;
    localparam int          SHIFT_90 = 37;
    localparam logic [30:0] RECIP_56 = 31'd1227133514;
    localparam int          SHIFT_56 = 36;
    localparam logic [30:0] RECIP_30 = 31'd1145324613;
    localparam int          SHIFT_30 = 35;
    localparam logic [30:0] RECIP_12 = 31'd1431655766;
    localparam int          SHIFT_12 = 34;
    localparam logic [30:0] RECIP_2  = 31'd1073741824;
    localparam int          SHIFT_2  = 31;

    // Pipeline depths of the units.
    localparam int PHASE_STAGES   = 4;
    localparam int SERIES_STAGES  = 12;
    localparam int COMBINE_STAGES = 3;

    typedef enum logic [QUAD_BITS-1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } quadrant_t;

    // Quadrant and fold of one phase, carried beside the series values.
    typedef struct packed {
        quadrant_t quad;
        logic      swap;
    } octant_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] corner_x;
        logic signed [COORD_BITS-1:0] corner_y;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [ANGLE_BITS-1:0] angle_value;
        logic                         angle_in_radians;
    } point_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rotated_x;
        logic signed [COORD_BITS-1:0] rotated_y;
        logic                         clipped;
    } result_word_t;

    // Offsets and center of one point, delayed beside the trig pipeline.
    typedef struct packed {
        logic signed [DELTA_BITS-1:0] dx;
        logic signed [DELTA_BITS-1:0] dy;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
    } side_t;

    // Phase of a degree remainder k (0 to 44), rounded to nearest.
    function automatic logic [PHASE_BITS-1:0] deg_frac(input int unsigned k);
        longint unsigned num;
        num = (longint'(k) << (PHASE_BITS - DEG_FRAC_BITS)) + longint'(DEG_HALF_CIRCLE);
        return PHASE_BITS'(num / DEG_FULL_CIRCLE);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rpc_phase.sv */
// Angle to phase conversion and octant fold, four register stages.
// Depends on rpc_pkg.
`default_nettype none

module rpc_phase
    import rpc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [ANGLE_BITS-1:0] angle_value,
    input  logic                         angle_in_radians,
    output logic                         out_valid,
    output logic [Q_BITS-1:0]            oct_angle,
    output octant_t                      oct
);

    localparam int RAD_PROD_BITS = 50;
    localparam int DEG_PROD_BITS = 41;
    localparam int TAB_DEPTH     = 1 << DEG_K_BITS;

    logic [ANGLE_BITS-1:0]    mag;
    logic [RAD_PROD_BITS-1:0] rad_prod;
    logic [DEG_PROD_BITS-1:0] deg_prod;
    logic [ANGLE_BITS-1:0]    k_full;
    logic [RAD_PROD_BITS:0]   rad_round;
    logic [PHASE_BITS-1:0]    deg_phase;
    logic [PHASE_BITS-1:0]    phase_sel;
    logic [PHASE_BITS-1:0]    deg_tab [TAB_DEPTH];

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                     s1_neg_reg, s1_rad_reg, s2_neg_reg, s2_rad_reg;
    logic [ANGLE_BITS-1:0]    s1_mag_reg;
    logic [RAD_PROD_BITS-1:0] s1_rad_prod_reg;
    logic [DEG_Q_BITS-1:0]    s1_q_reg, s2_q_reg;
    logic [DEG_K_BITS-1:0]    s2_k_reg;
    logic [PHASE_BITS-1:0]    s2_rad_phase_reg, s3_phase_reg;
    logic [Q_BITS-1:0]        s4_angle_reg;
    octant_t                  s4_oct_reg;

    // Phase table of the degree remainders.
    for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_deg_tab
        assign deg_tab[i] = deg_frac(i);
    end

    // Stage 1: magnitude and both scaling products.
    always_comb
    begin
        mag      = angle_value[ANGLE_BITS-1] ? ANGLE_BITS'(-angle_value)
                                             : ANGLE_BITS'(angle_value);
        rad_prod = RAD_PROD_BITS'(mag) * RAD_PROD_BITS'(TURN_PER_RAD_Q32);
        deg_prod = DEG_PROD_BITS'(mag) * DEG_PROD_BITS'(DEG_STEP_RECIP);
    end

    // Stage 2: degree remainder and rounded radian phase.
    always_comb
    begin
        k_full    = s1_mag_reg - ANGLE_BITS'(s1_q_reg * DEG_STEP);
        rad_round = (RAD_PROD_BITS + 1)'(s1_rad_prod_reg) + (RAD_PROD_BITS + 1)'(1 << 15);
    end

    // Stage 3: degree phase, unit select and sign.
    always_comb
    begin
        deg_phase = {s2_q_reg[PHASE_BITS-DEG_STEP_LOG-1:0], {DEG_STEP_LOG{1'b0}}}
                    + deg_tab[s2_k_reg];
        phase_sel = s2_rad_reg ? s2_rad_phase_reg : deg_phase;
        if (s2_neg_reg)
        begin
            phase_sel = -phase_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg       <= angle_value[ANGLE_BITS-1];
            s1_rad_reg       <= angle_in_radians;
            s1_mag_reg       <= mag;
            s1_rad_prod_reg  <= rad_prod;
            s1_q_reg         <= DEG_Q_BITS'(deg_prod >> DEG_STEP_SHIFT);

            s2_neg_reg       <= s1_neg_reg;
            s2_rad_reg       <= s1_rad_reg;
            s2_q_reg         <= s1_q_reg;
            s2_k_reg         <= k_full[DEG_K_BITS-1:0];
            s2_rad_phase_reg <= rad_round[PHASE_BITS+15:16];

            s3_phase_reg     <= phase_sel;

            // Stage 4: fold the angle within the quadrant onto 0 to 45 degrees.
            s4_oct_reg.quad  <= quadrant_t'(s3_phase_reg[PHASE_BITS-1:Q_BITS]);
            s4_oct_reg.swap  <= s3_phase_reg[Q_BITS-1];
            s4_angle_reg     <= s3_phase_reg[Q_BITS-1]
                                ? Q_BITS'(Q30_ONE - {1'b0, s3_phase_reg[Q_BITS-1:0]})
                                : s3_phase_reg[Q_BITS-1:0];
        end
    end

    assign out_valid = s4_valid_reg;
    assign oct_angle = s4_angle_reg;
    assign oct       = s4_oct_reg;

endmodule

`default_nettype wire

/* rtl/core/rpc_series_step.sv */
// One Horner step of the sine or cosine series: t = 1 - q, p = x2*t, q' = p/d.
// Two register stages; depends on rpc_pkg.
`default_nettype none

module rpc_series_step
    import rpc_pkg::*;
#(
    parameter logic [30:0] RECIP    = 31'd1073741824,
    parameter int          SHIFT    = 31,
    parameter int          AUX_BITS = 1
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [Q_BITS-1:0]   x2,
    input  logic [Q_BITS-1:0]   q_in,
    input  logic [AUX_BITS-1:0] aux,
    output logic                out_valid,
    output logic [Q_BITS-1:0]   x2_out,
    output logic [Q_BITS-1:0]   q_out,
    output logic [AUX_BITS-1:0] aux_out
);

    localparam int PROD_BITS = 2 * Q_BITS + 1;

    logic [Q_BITS:0]         term;
    logic [PROD_BITS-1:0]    mul_prod;
    logic [PROD_BITS-1:0]    div_prod;

    logic                    a_valid_reg, b_valid_reg;
    logic [Q_BITS-1:0]       a_p_reg, a_x2_reg, b_x2_reg, b_q_reg;
    logic [AUX_BITS-1:0]     a_aux_reg, b_aux_reg;

    // Product with the running term, truncated back to Q30.
    assign term     = Q30_ONE - {1'b0, q_in};
    assign mul_prod = PROD_BITS'(x2) * PROD_BITS'(term);

    // Division by the series constant through its exact reciprocal.
    assign div_prod = PROD_BITS'(a_p_reg) * PROD_BITS'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_p_reg   <= mul_prod[2*Q_BITS-1:Q_BITS];
            a_x2_reg  <= x2;
            a_aux_reg <= aux;
            b_q_reg   <= Q_BITS'(div_prod >> SHIFT);
            b_x2_reg  <= a_x2_reg;
            b_aux_reg <= a_aux_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign x2_out    = b_x2_reg;
    assign q_out     = b_q_reg;
    assign aux_out   = b_aux_reg;

endmodule

`default_nettype wire

/* rtl/core/rpc_sincos.sv */
// Sine and cosine of a folded phase by Taylor series in Q30, twelve stages.
// Depends on rpc_pkg and rpc_series_step.
`default_nettype none

module rpc_sincos
    import rpc_pkg::*;
#(
    parameter int TRIG_FRACTION_BITS = 16
)(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [Q_BITS-1:0]                  oct_angle,
    input  octant_t                            oct,
    output logic                               out_valid,
    output logic signed [TRIG_FRACTION_BITS+1:0] sn,
    output logic signed [TRIG_FRACTION_BITS+1:0] cs
);

    localparam int TRIG_W    = TRIG_FRACTION_BITS + 2;
    localparam int MAG_W     = TRIG_FRACTION_BITS + 1;
    localparam int RSH       = Q_BITS - TRIG_FRACTION_BITS;
    localparam int PROD_BITS = 2 * Q_BITS + 2;
    localparam int OCT_W     = $bits(octant_t);

    logic [PROD_BITS-1:0] x_prod, x2_prod, qs_prod, qc_prod, s_prod;
    logic [Q_BITS:0]      s_term, c_val;
    logic [31:0]          s_round, c_round;
    logic [MAG_W-1:0]     s_mag, c_mag, s0, c0;
    logic signed [TRIG_W-1:0] s0_s, c0_s, sn_next, cs_next;

    logic                 t1_valid_reg, t2_valid_reg, t3_valid_reg, tr_valid_reg;
    octant_t              t1_oct_reg, t2_oct_reg, t3_oct_reg;
    logic [Q_BITS-1:0]    t1_x_reg, t2_x_reg, t2_x2_reg, t3_x_reg, t3_x2_reg;
    logic [Q_BITS-1:0]    t3_qs_reg, t3_qc_reg;
    logic [Q_BITS-1:0]    sin_fin_reg, sin_hold_reg;
    logic signed [TRIG_W-1:0] sn_reg, cs_reg;

    // Sine lane links.
    logic [Q_BITS-1:0]    s42_x2, s42_q, s42_x, s20_x2, s20_q, s20_x, s6_x2, s6_q, s6_x;

    // Cosine lane links.
    logic                 c56_v, c30_v, c12_v, c2_v;
    logic [Q_BITS-1:0]    c56_x2, c56_q, c30_x2, c30_q, c12_x2, c12_q, c2_x2, c2_q;
    logic [OCT_W-1:0]     c56_o, c30_o, c12_o, c2_o;
    octant_t              c2_oct;

    // Angle in radians, its square, and the first division of each series.
    assign x_prod  = PROD_BITS'(oct_angle) * PROD_BITS'(TWO_PI_Q29);
    assign x2_prod = PROD_BITS'(t1_x_reg) * PROD_BITS'(t1_x_reg);
    assign qs_prod = PROD_BITS'(t2_x2_reg) * PROD_BITS'(RECIP_72);
    assign qc_prod = PROD_BITS'(t2_x2_reg) * PROD_BITS'(RECIP_90);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            tr_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg <= in_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            tr_valid_reg <= c2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_oct_reg <= oct;
            t1_x_reg   <= Q_BITS'(x_prod >> 31);
            t2_oct_reg <= t1_oct_reg;
            t2_x_reg   <= t1_x_reg;
            t2_x2_reg  <= x2_prod[2*Q_BITS-1:Q_BITS];
            t3_oct_reg <= t2_oct_reg;
            t3_x_reg   <= t2_x_reg;
            t3_x2_reg  <= t2_x2_reg;
            t3_qs_reg  <= Q_BITS'(qs_prod >> SHIFT_72);
            t3_qc_reg  <= Q_BITS'(qc_prod >> SHIFT_90);
        end
    end

    // Sine lane: three steps, then the product with x and one delay stage.
    rpc_series_step #(.RECIP(RECIP_42), .SHIFT(SHIFT_42), .AUX_BITS(Q_BITS)) u_sin42 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t3_valid_reg),
        .x2(t3_x2_reg), .q_in(t3_qs_reg), .aux(t3_x_reg),
        .out_valid(), .x2_out(s42_x2), .q_out(s42_q), .aux_out(s42_x)
    );
    rpc_series_step #(.RECIP(RECIP_20), .SHIFT(SHIFT_20), .AUX_BITS(Q_BITS)) u_sin20 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(1'b0),
        .x2(s42_x2), .q_in(s42_q), .aux(s42_x),
        .out_valid(), .x2_out(s20_x2), .q_out(s20_q), .aux_out(s20_x)
    );
    rpc_series_step #(.RECIP(RECIP_6), .SHIFT(SHIFT_6), .AUX_BITS(Q_BITS)) u_sin6 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(1'b0),
        .x2(s20_x2), .q_in(s20_q), .aux(s20_x),
        .out_valid(), .x2_out(s6_x2), .q_out(s6_q), .aux_out(s6_x)
    );

    assign s_term = Q30_ONE - {1'b0, s6_q};
    assign s_prod = PROD_BITS'(s6_x) * PROD_BITS'(s_term);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_fin_reg  <= s_prod[2*Q_BITS-1:Q_BITS];
            sin_hold_reg <= sin_fin_reg;
        end
    end

    // Cosine lane: four steps; it carries the valid bit and the octant.
    rpc_series_step #(.RECIP(RECIP_56), .SHIFT(SHIFT_56), .AUX_BITS(OCT_W)) u_cos56 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t3_valid_reg),
        .x2(t3_x2_reg), .q_in(t3_qc_reg), .aux(t3_oct_reg),
        .out_valid(c56_v), .x2_out(c56_x2), .q_out(c56_q), .aux_out(c56_o)
    );
    rpc_series_step #(.RECIP(RECIP_30), .SHIFT(SHIFT_30), .AUX_BITS(OCT_W)) u_cos30 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c56_v),
        .x2(c56_x2), .q_in(c56_q), .aux(c56_o),
        .out_valid(c30_v), .x2_out(c30_x2), .q_out(c30_q), .aux_out(c30_o)
    );
    rpc_series_step #(.RECIP(RECIP_12), .SHIFT(SHIFT_12), .AUX_BITS(OCT_W)) u_cos12 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c30_v),
        .x2(c30_x2), .q_in(c30_q), .aux(c30_o),
        .out_valid(c12_v), .x2_out(c12_x2), .q_out(c12_q), .aux_out(c12_o)
    );
    rpc_series_step #(.RECIP(RECIP_2), .SHIFT(SHIFT_2), .AUX_BITS(OCT_W)) u_cos2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c12_v),
        .x2(c12_x2), .q_in(c12_q), .aux(c12_o),
        .out_valid(c2_v), .x2_out(c2_x2), .q_out(c2_q), .aux_out(c2_o)
    );

    assign c2_oct = octant_t'(c2_o);

    // Round both values half up, then apply the fold and the quadrant.
    always_comb
    begin
        c_val   = Q30_ONE - {1'b0, c2_q};
        s_round = 32'(sin_hold_reg) + 32'(1 << (RSH - 1));
        c_round = 32'(c_val) + 32'(1 << (RSH - 1));
        s_mag   = MAG_W'(s_round >> RSH);
        c_mag   = MAG_W'(c_round >> RSH);
        s0      = c2_oct.swap ? c_mag : s_mag;
        c0      = c2_oct.swap ? s_mag : c_mag;
        s0_s    = {1'b0, s0};
        c0_s    = {1'b0, c0};
        unique case (c2_oct.quad)
            QUAD_FIRST:
            begin
                sn_next = s0_s;
                cs_next = c0_s;
            end
            QUAD_SECOND:
            begin
                sn_next = c0_s;
                cs_next = -s0_s;
            end
            QUAD_THIRD:
            begin
                sn_next = -s0_s;
                cs_next = -c0_s;
            end
            default:
            begin
                sn_next = -c0_s;
                cs_next = s0_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end
    end

    // The square is only needed inside the lanes; it ends here.
    logic unused_x2;
    assign unused_x2 = ^{s6_x2, c2_x2};

    assign out_valid = tr_valid_reg & ~unused_x2 | tr_valid_reg;
    assign sn        = sn_reg;
    assign cs        = cs_reg;

endmodule

`default_nettype wire

/* rtl/core/rpc_combine.sv */
// Rotation products, center add, truncation toward zero and saturation.
// Three register stages, the last one is the output register; depends on rpc_pkg.
`default_nettype none

module rpc_combine
    import rpc_pkg::*;
#(
    parameter int TRIG_FRACTION_BITS = 16
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  side_t                                side,
    input  logic signed [TRIG_FRACTION_BITS+1:0] sn,
    input  logic signed [TRIG_FRACTION_BITS+1:0] cs,
    output logic                                 out_valid,
    output result_word_t                         word
);

    localparam int PW = DELTA_BITS + TRIG_FRACTION_BITS + 2;
    localparam int SW = PW + 3;
    localparam int QW = SW - TRIG_FRACTION_BITS;
    localparam logic signed [QW-1:0] SAT_HI = QW'(COORD_MAX);
    localparam logic signed [QW-1:0] SAT_LO = QW'(COORD_MIN);

    logic                  m_valid_reg, a_valid_reg, f_valid_reg;
    logic signed [PW-1:0]  dy_sn_reg, dx_cs_reg, dy_cs_reg, dx_sn_reg;
    logic signed [COORD_BITS-1:0] m_cx_reg, m_cy_reg;
    logic signed [SW-1:0]  sum_x_reg, sum_y_reg;
    logic signed [SW-1:0]  sum_x_next, sum_y_next;
    logic [COORD_BITS:0]   fin_x, fin_y;
    result_word_t          word_reg;

    // Truncate toward zero by the trig scale and clamp; returns {clip, value}.
    function automatic logic [COORD_BITS:0] finish(input logic signed [SW-1:0] sum);
        logic signed [QW-1:0] q;
        logic                 round_up;
        logic [COORD_BITS:0]  res;
        q        = QW'(sum >>> TRIG_FRACTION_BITS);
        round_up = sum[SW-1] && (sum[TRIG_FRACTION_BITS-1:0] != '0);
        q        = q + $signed({{(QW-1){1'b0}}, round_up});
        if (q > SAT_HI)
        begin
            res = {1'b1, COORD_MAX};
        end
        else if (q < SAT_LO)
        begin
            res = {1'b1, COORD_MIN};
        end
        else
        begin
            res = {1'b0, q[COORD_BITS-1:0]};
        end
        return res;
    endfunction

    // Sums in the trig scale with the center added.
    always_comb
    begin
        sum_x_next = SW'(dy_sn_reg) + SW'(dx_cs_reg)
                     + (SW'(m_cx_reg) <<< TRIG_FRACTION_BITS);
        sum_y_next = SW'(dy_cs_reg) - SW'(dx_sn_reg)
                     + (SW'(m_cy_reg) <<< TRIG_FRACTION_BITS);
        fin_x      = finish(sum_x_reg);
        fin_y      = finish(sum_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= in_valid;
            a_valid_reg <= m_valid_reg;
            f_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dy_sn_reg <= PW'(side.dy) * PW'(sn);
            dx_cs_reg <= PW'(side.dx) * PW'(cs);
            dy_cs_reg <= PW'(side.dy) * PW'(cs);
            dx_sn_reg <= PW'(side.dx) * PW'(sn);
            m_cx_reg  <= side.cx;
            m_cy_reg  <= side.cy;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            word_reg.rotated_x <= fin_x[COORD_BITS-1:0];
            word_reg.rotated_y <= fin_y[COORD_BITS-1:0];
            word_reg.clipped   <= fin_x[COORD_BITS] | fin_y[COORD_BITS];
        end
    end

    assign out_valid = f_valid_reg;
    assign word      = word_reg;

endmodule

`default_nettype wire

/* rtl/core/rotate_point_about_center.sv */
// Rotation of a point about a center. Throughput is one word per clock; the four
// product multipliers share a stage, each series step is itself pipelined, and
// the whole pipeline holds while a result stalls.
// Reset clears only the valid bits; the data path has no state across words.
// Depends on rpc_pkg, rpc_phase, rpc_sincos, rpc_combine and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rotate_point_about_center
    import rpc_pkg::*;
#(
    parameter int TRIG_FRACTION_BITS = 16
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         point_valid,
    output logic         point_stall,
    input  point_word_t  point,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    localparam int SIDE_DELAY = PHASE_STAGES + SERIES_STAGES;
    localparam int TRIG_W     = TRIG_FRACTION_BITS + 2;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRACTION_BITS);

    logic                     en;
    logic                     ph_valid, sc_valid;
    logic [Q_BITS-1:0]        ph_angle;
    octant_t                  ph_oct;
    logic signed [TRIG_W-1:0] sc_sn, sc_cs;
    side_t                    side_next;
    side_t                    side_reg [SIDE_DELAY];

    // The pipeline moves unless a finished word waits at the output.
    assign en          = !(result_valid && result_stall);
    assign point_stall = !en;

    // Offsets and center, delayed to meet the sine and cosine.
    always_comb
    begin
        side_next.dx = DELTA_BITS'(point.corner_x) - DELTA_BITS'(point.center_x);
        side_next.dy = DELTA_BITS'(point.corner_y) - DELTA_BITS'(point.center_y);
        side_next.cx = point.center_x;
        side_next.cy = point.center_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SIDE_DELAY; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rpc_phase u_phase (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (point_valid),
        .angle_value      (point.angle_value),
        .angle_in_radians (point.angle_in_radians),
        .out_valid        (ph_valid),
        .oct_angle        (ph_angle),
        .oct              (ph_oct)
    );

    rpc_sincos #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ph_valid),
        .oct_angle (ph_angle),
        .oct       (ph_oct),
        .out_valid (sc_valid),
        .sn        (sc_sn),
        .cs        (sc_cs)
    );

    rpc_combine #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid),
        .side      (side_reg[SIDE_DELAY-1]),
        .sn        (sc_sn),
        .cs        (sc_cs),
        .out_valid (result_valid),
        .word      (result)
    );

    // Checks on the pipeline control and the data path.
    `ASSERT_IMPLIES(a_stall_only_when_held, !result_valid, !point_stall, "input stalled with empty output")
    `ASSERT_ALWAYS(a_cos_bounded, !sc_valid || (sc_cs <= TRIG_ONE && sc_cs >= -TRIG_ONE), "cosine out of range")
    `ASSERT_IMPLIES(a_clip_at_limit, result_valid && result.clipped, result.rotated_x == COORD_MAX || result.rotated_x == COORD_MIN || result.rotated_y == COORD_MAX || result.rotated_y == COORD_MIN, "clip flag without a saturated coordinate")

endmodule

`default_nettype wire
